### hw/rtl/aspt_pkg.sv
// Shared types and constants for the speed and power tracker.
// Used by the top level, the shared arithmetic unit and the port checker.
package aspt_pkg;

  // arithmetic unit operand and counter widths
  localparam int AW = 112;
  localparam int DW = 48;
  localparam int CW = $clog2(AW + 1);

  // stream word widths
  localparam int IN_W  = 40;
  localparam int OUT_W = 304;

  // scale and rounding constants
  localparam logic [63:0] AccScale  = 64'd980665;
  localparam logic [63:0] AccDiv    = 64'd100000;
  localparam logic [63:0] AccHalf   = 64'd50000;
  localparam logic [63:0] DtDiv     = 64'd2000000;
  localparam logic [63:0] DtHalf    = 64'd1000000;
  localparam logic [63:0] UsPerSec  = 64'd1000000;
  localparam logic [63:0] MilliDiv  = 64'd1000;
  localparam logic [63:0] MilliHalf = 64'd500;
  localparam logic [63:0] CubeDiv   = 64'd10000000000;
  localparam logic [63:0] MwScale   = 64'd100000;
  localparam logic [63:0] HpDiv     = 64'd74569987;
  localparam logic [63:0] HpHalf    = 64'd37284993;

  localparam logic [11:0] MassReset  = 12'd850;
  localparam logic [15:0] DragReset  = 16'd2848;
  localparam logic [6:0]  StepReset  = 7'd10;
  localparam logic [3:0]  CountReset = 4'd10;

  typedef enum logic [1:0] {
    CFG_MASS  = 2'd0,
    CFG_DRAG  = 2'd1,
    CFG_STEP  = 2'd2,
    CFG_COUNT = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ACC_MUL,
    ST_ACC_DIV,
    ST_V_MUL,
    ST_V_DIV,
    ST_D_MUL,
    ST_D_DIV,
    ST_AVG_MUL,
    ST_AVG_DIV,
    ST_T1_MUL1,
    ST_T1_MUL2,
    ST_T1_DIV,
    ST_T2_MUL1,
    ST_T2_MUL2,
    ST_T2_MUL3,
    ST_T2_DIV,
    ST_P_MUL,
    ST_P_DIV,
    ST_AP_DIV,
    ST_FINISH
  } seq_state_e;

  typedef struct packed {
    logic            start;
    arith_op_e       op;
    logic [AW-1:0]   a;
    logic [63:0]     b;
  } arith_req_t;

  typedef struct packed {
    logic            done;
    logic [AW-1:0]   res;
  } arith_rsp_t;

endpackage

### hw/rtl/accel_speed_power_tracker.sv
// Top level of the speed and power tracker: sequencer, state and stream ports.
// Depends on aspt_pkg and on aspt_arith, the shared multiply/divide unit.
//
// One acceleration word in, one result word out. Every sample runs through a
// sequencer that drives a single shift-add multiplier and a single restoring
// divider; s_axis_tready_o is low while a sample is in work. A sample runs
// through six to eight divisions and nine or ten multiplies, one at a time.
// The finished result sits in an output register, so the next sample is
// taken while the previous result waits on m_axis_tready_i.
// Configuration writes take effect at once and should be made while idle.
module accel_speed_power_tracker import aspt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [14:0] accel_milli_g, [34:15] dt_us
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // [31:0] speed_mm_s, [63:32] max_speed_mm_s, [111:64] distance_mm,
  // [143:112] avg_speed_mm_s, [175:144] power_mhp, [207:176] peak_power_mhp,
  // [238:208] avg_power_mhp, [239] checkpoint_hit, [250:240] checkpoint_kmh,
  // [298:251] checkpoint_time_us
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  seq_state_e state_q, state_d;
  logic       go_q, go_d;
  arith_req_t req;
  arith_rsp_t rsp;

  logic [11:0] mass_q, mass_d;
  logic [15:0] drag_q, drag_d;
  logic [6:0]  step_q, step_d;
  logic [3:0]  count_q, count_d;

  logic [31:0] prev_speed_q, prev_speed_d;
  logic [18:0] prev_accel_q, prev_accel_d;
  logic [47:0] dist_total_q, dist_total_d;
  logic [47:0] elapsed_q, elapsed_d;
  logic [31:0] top_speed_q, top_speed_d;
  logic [31:0] top_power_q, top_power_d;
  logic [63:0] power_sum_q, power_sum_d;
  logic [31:0] pos_cnt_q, pos_cnt_d;
  logic [4:0]  cp_idx_q, cp_idx_d;

  logic [14:0]   am_q, am_d;
  logic [19:0]   dt_q, dt_d;
  logic [18:0]   acc_q, acc_d;
  logic [31:0]   v_q, v_d;
  logic [47:0]   dist_q, dist_d;
  logic [31:0]   avg_q, avg_d;
  logic [53:0]   t1_q, t1_d;
  logic [60:0]   t2_q, t2_d;
  logic [47:0]   aux_q, aux_d;
  logic [AW-1:0] tmp_q, tmp_d;
  logic [31:0]   p_q, p_d;
  logic [30:0]   avgp_q, avgp_d;

  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q, out_data_d;

  // derived operands
  logic [14:0] am_mag;
  logic [18:0] acc_mag;
  logic [31:0] v_mag;
  logic [47:0] dist_mag;
  logic [19:0] as20, as_mag;
  logic [32:0] vs33, vs_mag;
  logic [63:0] t2_sgn, pmw, pmw_abs;
  logic [44:0] pmw_mag;
  logic [48:0] el49;
  logic [33:0] vq34, vsum34;
  logic [49:0] dq50, dsum50;
  logic        pos_add;
  logic [63:0] sum_n;
  logic [31:0] cnt_n;
  logic [31:0] top_speed_n, top_power_n;
  logic [11:0] target;
  logic [25:0] target_k;
  logic [38:0] v36;
  logic        hit;

  function automatic logic [31:0] signed_cap32(input logic [AW-1:0] q, input logic neg);
    logic [31:0] cap;
    logic [31:0] m;
    cap = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    m   = (|q[AW-1:32] || q[31:0] > cap) ? cap : q[31:0];
    return neg ? (~m + 32'd1) : m;
  endfunction

  assign am_mag   = am_q[14] ? (~am_q + 15'd1) : am_q;
  assign acc_mag  = acc_q[18] ? (~acc_q + 19'd1) : acc_q;
  assign v_mag    = v_q[31] ? (~v_q + 32'd1) : v_q;
  assign dist_mag = dist_q[47] ? (~dist_q + 48'd1) : dist_q;
  assign as20     = {acc_q[18], acc_q} + {prev_accel_q[18], prev_accel_q};
  assign as_mag   = as20[19] ? (~as20 + 20'd1) : as20;
  assign vs33     = {v_q[31], v_q} + {prev_speed_q[31], prev_speed_q};
  assign vs_mag   = vs33[32] ? (~vs33 + 33'd1) : vs33;

  // power in mW before clamping; the drag term takes the sign of the speed
  assign t2_sgn  = v_q[31] ? (~{3'b0, t2_q} + 64'd1) : {3'b0, t2_q};
  assign pmw     = {{10{t1_q[53]}}, t1_q} + t2_sgn;
  assign pmw_abs = pmw[63] ? (~pmw + 64'd1) : pmw;
  assign pmw_mag = (pmw_abs > 64'h1000_0000_0000) ? 45'h1000_0000_0000 : pmw_abs[44:0];

  assign el49 = {1'b0, elapsed_q} + 49'(s_axis_tdata_i[34:15]);

  assign vq34   = {14'b0, rsp.res[19:0]};
  assign vsum34 = {{2{prev_speed_q[31]}}, prev_speed_q} + (as20[19] ? (~vq34 + 34'd1) : vq34);
  assign dq50   = {18'b0, rsp.res[31:0]};
  assign dsum50 = {{2{dist_total_q[47]}}, dist_total_q} + (vs33[32] ? (~dq50 + 50'd1) : dq50);

  assign pos_add = !p_q[31] && (p_q != '0) && (pos_cnt_q != 32'hFFFF_FFFF);
  assign sum_n   = pos_add ? power_sum_q + {32'b0, p_q} : power_sum_q;
  assign cnt_n   = pos_add ? pos_cnt_q + 32'd1 : pos_cnt_q;

  assign top_speed_n = ($signed(v_q) > $signed(top_speed_q)) ? v_q : top_speed_q;
  assign top_power_n = ($signed(p_q) > $signed(top_power_q)) ? p_q : top_power_q;

  assign target   = 12'(step_q) * 12'(cp_idx_q + 5'd1);
  assign target_k = 26'(target) * 26'd10000;
  assign v36      = ({{7{v_q[31]}}, v_q} << 5) + ({{7{v_q[31]}}, v_q} << 2);
  assign hit      = (step_q != '0) && (cp_idx_q < {1'b0, count_q}) &&
                    ($signed(v36) > $signed({13'b0, target_k}));

  aspt_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_comb begin
    state_d      = state_q;
    req          = '0;
    req.op       = OP_MUL;
    mass_d       = mass_q;
    drag_d       = drag_q;
    step_d       = step_q;
    count_d      = count_q;
    prev_speed_d = prev_speed_q;
    prev_accel_d = prev_accel_q;
    dist_total_d = dist_total_q;
    elapsed_d    = elapsed_q;
    top_speed_d  = top_speed_q;
    top_power_d  = top_power_q;
    power_sum_d  = power_sum_q;
    pos_cnt_d    = pos_cnt_q;
    cp_idx_d     = cp_idx_q;
    am_d         = am_q;
    dt_d         = dt_q;
    acc_d        = acc_q;
    v_d          = v_q;
    dist_d       = dist_q;
    avg_d        = avg_q;
    t1_d         = t1_q;
    t2_d         = t2_q;
    aux_d        = aux_q;
    tmp_d        = tmp_q;
    p_d          = p_q;
    avgp_d       = avgp_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MASS:  mass_d  = cfg_wdata_i[11:0];
        CFG_DRAG:  drag_d  = cfg_wdata_i;
        CFG_STEP:  step_d  = cfg_wdata_i[6:0];
        CFG_COUNT: count_d = cfg_wdata_i[3:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          am_d      = s_axis_tdata_i[14:0];
          dt_d      = s_axis_tdata_i[34:15];
          elapsed_d = el49[48] ? '1 : el49[47:0];
          state_d   = ST_ACC_MUL;
        end
      end
      ST_ACC_MUL: begin
        if (go_q) begin
          req.start = 1'b1;
          req.a     = AW'(am_mag);
          req.b     = AccScale;
        end else if (rsp.done) begin
          tmp_d   = rsp.res;
          state_d = ST_ACC_DIV;
        end
      end
      ST_ACC_DIV: begin
        if (go_q) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = tmp_q + AW'(AccHalf);
          req.b     = AccDiv;
        end else if (rsp.done) begin
          acc_d   = am_q[14] ? (~rsp.res[18:0] + 19'd1) : rsp.res[18:0];
          state_d = ST_V_MUL;
        end
      end
      ST_V_MUL: begin
        if (go_q) begin
          req.start = 1'b1;
          req.a     = AW'(as_mag);
          req.b     = 64'(dt_q);
        end else if (rsp.done) begin
          tmp_d   = rsp.res;
          state_d = ST_V_DIV;
        end
      end
      ST_V_DIV: begin
        if (go_q) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = tmp_q + AW'(DtHalf);
          req.b     = DtDiv;
        end else if (rsp.done) begin
          if (vsum34[33:31] == 3'b000 || vsum34[33:31] == 3'b111) begin
            v_d = vsum34[31:0];
          end else begin
            v_d = vsum34[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end
          state_d = ST_D_MUL;
        end
      end
      ST_D_MUL: begin
        if (go_q) begin
          req.start = 1'b1;
          req.a     = AW'(vs_mag);
          req.b     = 64'(dt_q);
        end else if (rsp.done) begin
          tmp_d   = rsp.res;
          state_d = ST_D_DIV;
        end
      end
      ST_D_DIV: begin
        if (go_q) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = tmp_q + AW'(DtHalf);
          req.b     = DtDiv;
        end else if (rsp.done) begin
          if (dsum50[49:47] == 3'b000 || dsum50[49:47] == 3'b111) begin
            dist_d = dsum50[47:0];
          end else begin
            dist_d = dsum50[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
          end
          state_d = ST_AVG_MUL;
        end
      end
      ST_AVG_MUL: begin
        if (go_q) begin
          if (elapsed_q == '0) begin
            avg_d   = '0;
            state_d = ST_T1_MUL1;
          end else begin
            req.start = 1'b1;
            req.a     = AW'(dist_mag);
            req.b     = UsPerSec;
          end
        end else if (rsp.done) begin
          tmp_d   = rsp.res;
          state_d = ST_AVG_DIV;
        end
      end
      ST_AVG_DIV: begin
        if (go_q) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = tmp_q;
          req.b     = 64'(elapsed_q);
        end else if (rsp.done) begin
          avg_d   = signed_cap32(rsp.res, dist_q[47]);
          state_d = ST_T1_MUL1;
        end
      end
      ST_T1_MUL1: begin
        if (go_q) begin
          req.start = 1'b1;
          req.a     = AW'(mass_q);
          req.b     = 64'(acc_mag);
        end else if (rsp.done) begin
          tmp_d   = rsp.res;
          state_d = ST_T1_MUL2;
        end
      end
      ST_T1_MUL2: begin
        if (go_q) begin
          req.start = 1'b1;
          req.a     = tmp_q;
          req.b     = 64'(v_mag);
        end else if (rsp.done) begin
          tmp_d   = rsp.res;
          state_d = ST_T1_DIV;
        end
      end
      ST_T1_DIV: begin
        if (go_q) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = tmp_q + AW'(MilliHalf);
          req.b     = MilliDiv;
        end else if (rsp.done) begin
          t1_d    = (acc_q[18] ^ v_q[31]) ? (~rsp.res[53:0] + 54'd1) : rsp.res[53:0];
          state_d = ST_T2_MUL1;
        end
      end
      ST_T2_MUL1: begin
        if (go_q) begin
          req.start = 1'b1;
          req.a     = AW'(drag_q);
          req.b     = 64'(v_mag);
        end else if (rsp.done) begin
          aux_d   = rsp.res[47:0];
          state_d = ST_T2_MUL2;
        end
      end
      ST_T2_MUL2: begin
        if (go_q) begin
          req.start = 1'b1;
          req.a     = AW'(v_mag);
          req.b     = 64'(v_mag);
        end else if (rsp.done) begin
          tmp_d   = rsp.res;
          state_d = ST_T2_MUL3;
        end
      end
      ST_T2_MUL3: begin
        if (go_q) begin
          req.start = 1'b1;
          req.a     = tmp_q;
          req.b     = 64'(aux_q);
        end else if (rsp.done) begin
          tmp_d   = rsp.res;
          state_d = ST_T2_DIV;
        end
      end
      ST_T2_DIV: begin
        if (go_q) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = tmp_q;
          req.b     = CubeDiv;
        end else if (rsp.done) begin
          // cap the drag term at 2^60
          t2_d    = (|rsp.res[AW-1:60]) ? {1'b1, 60'b0} : {1'b0, rsp.res[59:0]};
          state_d = ST_P_MUL;
        end
      end
      ST_P_MUL: begin
        if (go_q) begin
          req.start = 1'b1;
          req.a     = AW'(pmw_mag);
          req.b     = MwScale;
        end else if (rsp.done) begin
          tmp_d   = rsp.res;
          state_d = ST_P_DIV;
        end
      end
      ST_P_DIV: begin
        if (go_q) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = tmp_q + AW'(HpHalf);
          req.b     = HpDiv;
        end else if (rsp.done) begin
          p_d     = signed_cap32(rsp.res, pmw[63]);
          state_d = ST_AP_DIV;
        end
      end
      ST_AP_DIV: begin
        if (go_q) begin
          power_sum_d = sum_n;
          pos_cnt_d   = cnt_n;
          if (cnt_n == '0) begin
            avgp_d  = '0;
            state_d = ST_FINISH;
          end else begin
            req.start = 1'b1;
            req.op    = OP_DIV;
            req.a     = AW'(sum_n);
            req.b     = 64'(cnt_n);
          end
        end else if (rsp.done) begin
          avgp_d  = (|rsp.res[AW-1:31]) ? 31'h7FFF_FFFF : rsp.res[30:0];
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_data_d   = {5'b0,
                          hit ? elapsed_q : 48'b0,
                          hit ? target[10:0] : 11'b0,
                          hit,
                          avgp_q,
                          top_power_n,
                          p_q,
                          avg_q,
                          dist_q,
                          top_speed_n,
                          v_q};
          prev_speed_d = v_q;
          prev_accel_d = acc_q;
          dist_total_d = dist_q;
          top_speed_d  = top_speed_n;
          top_power_d  = top_power_n;
          if (hit) cp_idx_d = cp_idx_q + 5'd1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    go_d = (state_d != state_q);
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      go_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      mass_q       <= MassReset;
      drag_q       <= DragReset;
      step_q       <= StepReset;
      count_q      <= CountReset;
      prev_speed_q <= '0;
      prev_accel_q <= '0;
      dist_total_q <= '0;
      elapsed_q    <= '0;
      top_speed_q  <= '0;
      top_power_q  <= '0;
      power_sum_q  <= '0;
      pos_cnt_q    <= '0;
      cp_idx_q     <= '0;
    end else begin
      state_q      <= state_d;
      go_q         <= go_d;
      out_valid_q  <= out_valid_d;
      mass_q       <= mass_d;
      drag_q       <= drag_d;
      step_q       <= step_d;
      count_q      <= count_d;
      prev_speed_q <= prev_speed_d;
      prev_accel_q <= prev_accel_d;
      dist_total_q <= dist_total_d;
      elapsed_q    <= elapsed_d;
      top_speed_q  <= top_speed_d;
      top_power_q  <= top_power_d;
      power_sum_q  <= power_sum_d;
      pos_cnt_q    <= pos_cnt_d;
      cp_idx_q     <= cp_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    am_q       <= am_d;
    dt_q       <= dt_d;
    acc_q      <= acc_d;
    v_q        <= v_d;
    dist_q     <= dist_d;
    avg_q      <= avg_d;
    t1_q       <= t1_d;
    t2_q       <= t2_d;
    aux_q      <= aux_d;
    tmp_q      <= tmp_d;
    p_q        <= p_d;
    avgp_q     <= avgp_d;
    out_data_q <= out_data_d;
  end

endmodule

### hw/rtl/aspt_arith.sv
// Shared arithmetic unit: shift-add multiplier and restoring divider.
// Depends on aspt_pkg for widths and the request/response structs.
module aspt_arith import aspt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arith_req_t req_i,
  output arith_rsp_t rsp_o
);

  logic          busy_q, busy_d;
  arith_op_e     op_q, op_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [AW-1:0] mcand_q, mcand_d;
  logic [63:0]   mplier_q, mplier_d;
  logic [AW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   trial;
  logic          ge;
  logic          done;

  assign trial = {rem_q, quo_q[AW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d   = busy_q;
    op_d     = op_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    cnt_d    = cnt_q;
    done     = 1'b0;
    if (req_i.start) begin
      busy_d   = 1'b1;
      op_d     = req_i.op;
      acc_d    = '0;
      mcand_d  = req_i.a;
      mplier_d = req_i.b;
      quo_d    = req_i.a;
      rem_d    = '0;
      dvs_d    = req_i.b[DW-1:0];
      cnt_d    = CW'(AW);
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (mplier_q == '0) begin
            done   = 1'b1;
            busy_d = 1'b0;
          end else begin
            if (mplier_q[0]) acc_d = acc_q + mcand_q;
            mcand_d  = mcand_q << 1;
            mplier_d = mplier_q >> 1;
          end
        end
        OP_DIV: begin
          if (cnt_q == '0) begin
            done   = 1'b1;
            busy_d = 1'b0;
          end else begin
            // one quotient bit per cycle
            rem_d = ge ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
            quo_d = {quo_q[AW-2:0], ge};
            cnt_d = cnt_q - CW'(1);
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  assign rsp_o = '{done: done, res: ((op_q == OP_MUL) ? acc_q : quo_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= OP_MUL;
    end else begin
      busy_q <= busy_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    cnt_q    <= cnt_d;
  end

endmodule

### hw/rtl/aspt_checker.sv
// Port-level checks for the speed and power tracker, bound to the top level.
// Depends on aspt_pkg for the stream word widths.
module aspt_checker import aspt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic [1:0]       cfg_idx_i,
  input logic [15:0]      cfg_wdata_i,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic [IN_W-1:0]  s_axis_tdata_i,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // a sample keeps the block busy past the accept edge
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken again right after a sample");

  // without a hit the checkpoint fields stay zero
  a_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[239] |->
      m_axis_tdata_o[250:240] == '0 && m_axis_tdata_o[298:251] == '0)
    else $error("checkpoint fields set without a hit");

  // running maxima never fall below the current values
  a_max_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      $signed(m_axis_tdata_o[63:32]) >= $signed(m_axis_tdata_o[31:0]) &&
      $signed(m_axis_tdata_o[207:176]) >= $signed(m_axis_tdata_o[175:144]))
    else $error("maximum below current value");

endmodule

bind accel_speed_power_tracker aspt_checker u_aspt_checker (.*);

### sim/aspt_stream_checker.sv
`timescale 1ns / 1ps
// Port checker for the speed and power tracker: follows register writes and sample words,
// predicts each result word and compares it with what the block sends out.
// Depends on aspt_pkg for the stream widths, reset values and configuration index names.
module aspt_stream_checker import aspt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             s_axis_tvalid_i,
  input  logic             s_axis_tready_i,
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  input  logic             m_axis_tvalid_i,
  input  logic             m_axis_tready_i,
  input  logic [OUT_W-1:0] m_axis_tdata_i,
  output int               errors_o,
  output int               pending_o
);

  localparam longint unsigned Mask48 = 64'hFFFF_FFFF_FFFF;
  localparam longint S48Max = 64'sd140737488355327;
  localparam longint S48Min = -64'sd140737488355328;
  localparam longint PwrCap = 64'sd17592186044416;
  localparam longint unsigned CubeCap = 64'd1152921504606846976;
  localparam longint I32Max = 64'sd2147483647;
  localparam longint I32Min = -64'sd2147483648;

  typedef struct {
    logic [63:0] speed;
    logic [63:0] max_speed;
    logic [63:0] distance;
    logic [63:0] avg_speed;
    logic [63:0] power;
    logic [63:0] peak_power;
    logic [63:0] avg_power;
    logic [63:0] ckpt_hit;
    logic [63:0] ckpt_kmh;
    logic [63:0] ckpt_time;
  } track_result_t;

  // configuration copy
  logic [11:0] mass_kg;
  logic [15:0] drag;
  logic [6:0]  step_kmh;
  logic [3:0]  ckpt_count;

  // tracker state
  int               speed_prev, accel_prev, speed_top, power_top;
  longint           dist_total;
  longint unsigned  time_total, pwr_sum;
  int unsigned      pos_count, ckpt_idx;

  track_result_t result_q[$];

  function automatic longint round_div(longint n, longint unsigned d);
    longint unsigned m, q;
    m = (n < 0) ? longint'(-n) : longint'(n);
    q = (m + d / 2) / d;
    if (n < 0) return -longint'(q);
    return longint'(q);
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // floor(y * v2 / 1e10), split in base 1e5 limbs and capped
  function automatic longint unsigned drag_cube(longint unsigned y, longint unsigned v2);
    longint unsigned a, b, c, d, mid, lo, hi;
    a = v2 / 100000; b = v2 % 100000;
    c = y / 100000;  d = y % 100000;
    mid = a * d + b * c + (b * d) / 100000;
    lo = mid / 100000;
    if (c != 0 && a > CubeCap / c) return CubeCap;
    hi = a * c;
    if (hi >= CubeCap || lo >= CubeCap - hi) return CubeCap;
    return hi + lo;
  endfunction

  function automatic longint mean_speed(longint dist_n, longint unsigned t);
    logic neg;
    longint unsigned x, q, r, cap;
    if (t == 0) return 0;
    neg = dist_n < 0;
    x = neg ? longint'(-dist_n) : longint'(dist_n);
    q = x / t; r = x % t;
    cap = neg ? 64'd2147483648 : 64'd2147483647;
    if (q > 3000) return neg ? I32Min : I32Max;
    for (int i = 0; i < 2; i++) begin
      r = r * 1000;
      q = q * 1000 + r / t;
      r = r % t;
    end
    if (q > cap) q = cap;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic track_result_t track_sample(logic [IN_W-1:0] word);
    track_result_t res;
    longint am, acc, v, dist_n, t1, pmw, p, target, dt;
    longint unsigned mag, t2m, avg_p;
    am = longint'($signed(word[14:0]));
    dt = longint'(word[34:15]);
    acc = round_div(am * 980665, 100000);
    time_total = time_total + longint'(dt);
    if (time_total > Mask48) time_total = Mask48;

    v = longint'(speed_prev) + round_div((acc + longint'(accel_prev)) * dt, 2000000);
    v = clamp(v, I32Min, I32Max);
    if (v > longint'(speed_top)) speed_top = int'(v);

    dist_n = dist_total + round_div((v + longint'(speed_prev)) * dt, 2000000);
    dist_n = clamp(dist_n, S48Min, S48Max);

    t1 = round_div(longint'(mass_kg) * acc * v, 1000);
    mag = (v < 0) ? longint'(-v) : longint'(v);
    t2m = drag_cube(longint'(drag) * mag, mag * mag);
    if (v < 0) pmw = t1 - longint'(t2m);
    else pmw = t1 + longint'(t2m);
    pmw = clamp(pmw, -PwrCap, PwrCap);
    p = clamp(round_div(pmw * 100000, 74569987), I32Min, I32Max);

    if (p > longint'(power_top)) power_top = int'(p);
    if (p > 0 && pos_count != 32'hFFFF_FFFF) begin
      pwr_sum = pwr_sum + longint'(p);
      pos_count++;
    end
    avg_p = (pos_count != 0) ? pwr_sum / longint'(pos_count) : 0;
    if (avg_p > 64'h7FFF_FFFF) avg_p = 64'h7FFF_FFFF;

    res.ckpt_hit = 0; res.ckpt_kmh = 0; res.ckpt_time = 0;
    if (step_kmh != 0 && ckpt_idx < ckpt_count) begin
      target = longint'(step_kmh) * longint'(ckpt_idx + 1);
      if (v * 36 > target * 10000) begin
        res.ckpt_hit = 1;
        res.ckpt_kmh = target & 64'h7FF;
        res.ckpt_time = time_total;
        ckpt_idx++;
      end
    end

    speed_prev = int'(v);
    accel_prev = int'(acc);
    dist_total = dist_n;

    res.speed      = v & 64'hFFFF_FFFF;
    res.max_speed  = longint'(speed_top) & 64'hFFFF_FFFF;
    res.distance   = dist_n & Mask48;
    res.avg_speed  = mean_speed(dist_n, time_total) & 64'hFFFF_FFFF;
    res.power      = p & 64'hFFFF_FFFF;
    res.peak_power = longint'(power_top) & 64'hFFFF_FFFF;
    res.avg_power  = avg_p & 64'h7FFF_FFFF;
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
      errors_o++;
    end
  endfunction

  assign pending_o = result_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    track_result_t want;
    logic [OUT_W-1:0] w;
    if (!rst_ni) begin
      mass_kg <= MassReset; drag <= DragReset;
      step_kmh <= StepReset; ckpt_count <= CountReset;
      speed_prev = 0; accel_prev = 0; speed_top = 0; power_top = 0;
      dist_total = 0; time_total = 0; pwr_sum = 0; pos_count = 0; ckpt_idx = 0;
      errors_o = 0;
      result_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MASS:  mass_kg    <= cfg_wdata_i[11:0];
          CFG_DRAG:  drag       <= cfg_wdata_i;
          CFG_STEP:  step_kmh   <= cfg_wdata_i[6:0];
          CFG_COUNT: ckpt_count <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        w = m_axis_tdata_i;
        if (result_q.size() == 0) begin
          $display("%0t: result word with none expected: actual %h", $time, w);
          errors_o++;
        end else begin
          want = result_q.pop_front();
          check_field("speed_mm_s",         want.speed,      64'(w[31:0]));
          check_field("max_speed_mm_s",     want.max_speed,  64'(w[63:32]));
          check_field("distance_mm",        want.distance,   64'(w[111:64]));
          check_field("avg_speed_mm_s",     want.avg_speed,  64'(w[143:112]));
          check_field("power_mhp",          want.power,      64'(w[175:144]));
          check_field("peak_power_mhp",     want.peak_power, 64'(w[207:176]));
          check_field("avg_power_mhp",      want.avg_power,  64'(w[238:208]));
          check_field("checkpoint_hit",     want.ckpt_hit,   64'(w[239]));
          check_field("checkpoint_kmh",     want.ckpt_kmh,   64'(w[250:240]));
          check_field("checkpoint_time_us", want.ckpt_time,  64'(w[298:251]));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        result_q.push_back(track_sample(s_axis_tdata_i));
    end
  end

endmodule

### sim/tb_accel_speed_power_tracker.sv
`timescale 1ns / 1ps
// Testbench top for the speed and power tracker: clock, reset, register phases,
// sample stimulus with random gaps, and the verdict. Uses aspt_stream_checker.
module tb_accel_speed_power_tracker;
  import aspt_pkg::*;

  localparam int PhaseItems = 290;
  localparam longint CycleLimit = 64'd20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  int errors, pending, samples_sent, rx_stall, rx_hold;
  logic hold_done = 1'b0;
  longint cycles = 0;

  accel_speed_power_tracker DUT (.*);

  aspt_stream_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 6);
    return $urandom_range(20, 300);
  endfunction

  // receiver: random stalls, plus one long hold so the block backs up
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (!hold_done && samples_sent == 600) begin
      hold_done <= 1'b1;
      rx_hold <= 6000;
      m_axis_tready_i <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      rx_stall <= pick_gap();
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_sample(logic [14:0] accel, logic [19:0] dt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {5'd0, dt, accel};
    do @(posedge clk_i); while (!s_axis_tready_o);
    samples_sent++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  // runs of driving, braking and raw noise
  task automatic random_samples(int n);
    int mode, run, sent;
    logic [14:0] a;
    logic [19:0] dt;
    sent = 0;
    while (sent < n) begin
      mode = $urandom_range(0, 99);
      run = $urandom_range(3, 25);
      for (int i = 0; i < run && sent < n; i++) begin
        if (mode < 55) begin
          a = 15'($urandom_range(0, 16000));
          dt = 20'($urandom_range(10000, 1000000));
        end else if (mode < 85) begin
          a = 15'(-$urandom_range(0, 16000));
          dt = 20'($urandom_range(10000, 1000000));
        end else begin
          a = 15'($urandom);
          dt = 20'($urandom);
        end
        send_sample(a, dt);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset; zero time first, then field extremes
    send_sample(15'd0, 20'd0);
    send_sample(15'h3FFF, 20'd0);
    send_sample(15'h4000, 20'd1);
    send_sample(15'd16000, 20'd1000000);
    send_sample(15'd16000, 20'd1000000);
    send_sample(15'd16000, 20'hFFFFF);
    send_sample(15'h3FFF, 20'hFFFFF);
    send_sample(15'd0, 20'd500000);
    send_sample(15'(-16000), 20'd1000000);
    send_sample(15'h4000, 20'hFFFFF);
    send_sample(15'h4000, 20'hFFFFF);
    send_sample(15'h4000, 20'hFFFFF);
    send_sample(15'h7FFF, 20'd777);
    send_sample(15'd1, 20'd1);
    send_sample(15'h3FFF, 20'hFFFFF);
    send_sample(15'h3FFF, 20'hFFFFF);
    send_sample(15'h2AAA, 20'h55555);
    send_sample(15'h5555, 20'hAAAAA);
    send_sample(15'd0, 20'd0);
    random_samples(PhaseItems);
    drain();

    write_reg(CFG_MASS, 16'd4095);
    write_reg(CFG_DRAG, 16'hFFFF);
    write_reg(CFG_STEP, 16'd1);
    write_reg(CFG_COUNT, 16'd15);
    random_samples(PhaseItems);
    drain();

    write_reg(CFG_MASS, 16'd0);
    write_reg(CFG_DRAG, 16'd0);
    write_reg(CFG_STEP, 16'd0);
    write_reg(CFG_COUNT, 16'd0);
    random_samples(PhaseItems);
    drain();

    write_reg(CFG_MASS, 16'd1);
    write_reg(CFG_DRAG, 16'd1);
    write_reg(CFG_STEP, 16'd127);
    write_reg(CFG_COUNT, 16'd15);
    random_samples(PhaseItems);
    drain();

    // upper bits beyond each register's width are dropped
    write_reg(CFG_MASS, 16'($urandom));
    write_reg(CFG_DRAG, 16'($urandom));
    write_reg(CFG_STEP, 16'($urandom));
    write_reg(CFG_COUNT, 16'($urandom));
    random_samples(PhaseItems);
    drain();

    write_reg(CFG_MASS, 16'd850);
    write_reg(CFG_DRAG, 16'd2848);
    write_reg(CFG_STEP, 16'd100);
    write_reg(CFG_COUNT, 16'd15);
    random_samples(PhaseItems);

    drain();
    repeat (1500) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
